// ===== src/cnpm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the client name pattern matcher
package cnpm_pkg;

  localparam int CHAR_SLOTS = 32;
  localparam int CHAR_BITS  = 8 * CHAR_SLOTS;
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  localparam logic [7:0] CH_ANY      = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] MODE_CONTAINS = 2'd0;
  localparam logic [1:0] MODE_EXACT    = 2'd1;
  localparam logic [1:0] MODE_WILDCARD = 2'd2;

  localparam logic [2:0] REG_CHARS_A  = 3'd0;
  localparam logic [2:0] REG_CHARS_B  = 3'd1;
  localparam logic [2:0] REG_CHARS_C  = 3'd2;
  localparam logic [2:0] REG_CHARS_D  = 3'd3;
  localparam logic [2:0] REG_LENGTH   = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;
  localparam logic [2:0] REG_FOLD     = 3'd6;

  typedef struct packed {
    logic [CHAR_BITS-1:0] chars;
    logic [5:0]           length;
    logic [1:0]           mode;
    logic                 fold;
  } cfg_t;

  typedef struct packed {
    logic       wild;
    logic       start_pending;
    logic       load;
    logic [7:0] name_char;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic shift;
    logic clos;
  } cell_link_t;

  typedef struct packed {
    logic cur_end;
    logic next_end;
  } cell_stat_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== src/cnpm_name_if.sv =====
`timescale 1ns / 1ps
// request channel carrying one name byte per transfer
interface cnpm_name_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       is_last;
  logic       is_empty;

  modport source (output valid, output name_byte, output is_last, output is_empty,
                  input ready);
  modport sink (input valid, input name_byte, input is_last, input is_empty,
                output ready);
endinterface

// ===== src/cnpm_match_if.sv =====
`timescale 1ns / 1ps
// result channel carrying the match verdict
interface cnpm_match_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

// ===== src/cnpm_regs.sv =====
`timescale 1ns / 1ps
// apb configuration registers of the pattern matcher
module cnpm_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cnpm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cnpm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cnpm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output cnpm_pkg::cfg_t                      cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars  <= '0;
      cfg.length <= '0;
      cfg.mode   <= cnpm_pkg::MODE_CONTAINS;
      cfg.fold   <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        cnpm_pkg::REG_CHARS_A: cfg.chars[63:0]    <= pwdata;
        cnpm_pkg::REG_CHARS_B: cfg.chars[127:64]  <= pwdata;
        cnpm_pkg::REG_CHARS_C: cfg.chars[191:128] <= pwdata;
        cnpm_pkg::REG_CHARS_D: cfg.chars[255:192] <= pwdata;
        cnpm_pkg::REG_LENGTH:  cfg.length         <= pwdata[5:0];
        cnpm_pkg::REG_MODE:    cfg.mode           <= pwdata[1:0];
        cnpm_pkg::REG_FOLD:    cfg.fold           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cnpm_pkg::REG_CHARS_A: prdata = cfg.chars[63:0];
      cnpm_pkg::REG_CHARS_B: prdata = cfg.chars[127:64];
      cnpm_pkg::REG_CHARS_C: prdata = cfg.chars[191:128];
      cnpm_pkg::REG_CHARS_D: prdata = cfg.chars[255:192];
      cnpm_pkg::REG_LENGTH:  prdata = {58'd0, cfg.length};
      cnpm_pkg::REG_MODE:    prdata = {62'd0, cfg.mode};
      cnpm_pkg::REG_FOLD:    prdata = {63'd0, cfg.fold};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== src/cnpm_cell.sv =====
`timescale 1ns / 1ps
// one pattern position: holds its active bit and passes shift and closure on
module cnpm_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  cnpm_pkg::cell_ctl_t    ctl,
  input  logic                   enable,
  input  logic                   at_end,
  input  logic [7:0]             pat_char,
  input  cnpm_pkg::cell_link_t   link_in,
  output cnpm_pkg::cell_link_t   link_out,
  output cnpm_pkg::cell_stat_t   stat
);

  logic act;
  logic cur;
  logic nxt;
  logic hold;
  logic hit;

  // a star keeps its position alive in wildcard mode
  assign hold = ctl.wild & (pat_char == cnpm_pkg::CH_STAR);
  assign hit  = (pat_char == ctl.name_char) | (ctl.wild & (pat_char == cnpm_pkg::CH_ANY));
  assign cur  = ctl.start_pending ? link_in.start : act;
  assign nxt  = (enable & cur & hold) | link_in.shift | link_in.clos;

  assign link_out.start = link_in.start & enable & hold;
  assign link_out.shift = enable & cur & ~hold & hit;
  assign link_out.clos  = nxt & enable & hold;

  assign stat.cur_end  = cur & at_end;
  assign stat.next_end = nxt & at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (ctl.load) begin
      act <= nxt;
    end
  end

endmodule

// ===== src/cnpm_out_buf.sv =====
`timescale 1ns / 1ps
// two-entry output buffer for match verdicts
module cnpm_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 push_matched,
  output logic                 full,
  cnpm_match_if.source         rsp
);

  logic head_valid;
  logic head_matched;
  logic skid_valid;
  logic skid_matched;
  logic pop;

  assign pop         = head_valid & rsp.ready;
  assign rsp.valid   = head_valid;
  assign rsp.matched = head_matched;
  assign full        = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head_matched <= skid_matched;
        skid_valid   <= 1'b0;
      end
    end else if (head_valid && !pop) begin
      if (push) begin
        skid_valid   <= 1'b1;
        skid_matched <= push_matched;
      end
    end else begin
      head_valid <= push;
      if (push) begin
        head_matched <= push_matched;
      end
    end
  end

endmodule

// ===== src/client_name_pattern_matcher_unit.sv =====
`timescale 1ns / 1ps
// top level of the client name pattern matcher
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    name_byte[7:0], is_last, is_empty
//   rsp      out  valid/ready    matched
//   apb      in   psel/penable   paddr[5:0], pwdata[63:0] -> prdata[63:0]
//
// one name byte per cycle unless req stalls; the last request's verdict is registered
// the row of position cells updates the active vector on each accepted name byte
// rst clears the active vector and arms the start load; registers return to reset values
// req stalls only when both output buffer entries hold an untaken verdict
module client_name_pattern_matcher_unit #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  cnpm_name_if.sink                         req,
  cnpm_match_if.source                      rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cnpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cnpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cnpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  cnpm_pkg::cfg_t          cfg;
  cnpm_pkg::cell_ctl_t     ctl;
  cnpm_pkg::cell_link_t    link [PATTERN_MAX+2];
  cnpm_pkg::cell_stat_t    stat [PATTERN_MAX+1];

  logic [PATTERN_MAX:0] cur_end_vec;
  logic [PATTERN_MAX:0] next_end_vec;

  logic wild;
  logic contains;
  logic accept;
  logic done;
  logic buf_full;
  logic start_pending;
  logic found;
  logic cur_end;
  logic next_end;
  logic found_pre;
  logic found_new;
  logic matched;

  cnpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign wild     = (cfg.mode == cnpm_pkg::MODE_WILDCARD);
  assign contains = (cfg.mode != cnpm_pkg::MODE_WILDCARD) && (cfg.mode != cnpm_pkg::MODE_EXACT);

  assign req.ready = ~buf_full;
  assign accept    = req.valid & req.ready;
  assign done      = req.is_empty | req.is_last;

  assign ctl.wild          = wild;
  assign ctl.start_pending = start_pending;
  assign ctl.load          = accept & ~req.is_empty;
  assign ctl.name_char     = cnpm_pkg::fold_char(req.name_byte, cfg.fold);

  // position zero seeds the start vector and, in contains mode, restarts every byte
  assign link[0].start = 1'b1;
  assign link[0].shift = contains;
  assign link[0].clos  = 1'b0;

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
    logic [7:0] pat_char;
    logic       enable;
    logic       at_end;

    if (i < cnpm_pkg::CHAR_SLOTS) begin : g_stored
      assign pat_char = cnpm_pkg::fold_char(cfg.chars[8*i +: 8], cfg.fold);
    end else begin : g_blank
      assign pat_char = 8'h00;
    end

    if (i == PATTERN_MAX) begin : g_tail
      assign enable = 1'b0;
      assign at_end = ({1'b0, cfg.length} >= 7'(PATTERN_MAX));
    end else begin : g_body
      assign enable = ({1'b0, cfg.length} > 7'(i));
      assign at_end = ({1'b0, cfg.length} == 7'(i));
    end

    cnpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .enable   (enable),
      .at_end   (at_end),
      .pat_char (pat_char),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .stat     (stat[i])
    );

    assign cur_end_vec[i]  = stat[i].cur_end;
    assign next_end_vec[i] = stat[i].next_end & ~link[i+1].start;
  end

  assign cur_end   = |cur_end_vec;
  assign next_end  = |next_end_vec;
  assign found_pre = (found & ~start_pending) | (contains & cur_end);
  assign found_new = found_pre | (contains & ~req.is_empty & next_end);
  assign matched   = contains ? found_new : (req.is_empty ? cur_end : next_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending <= 1'b1;
      found         <= 1'b0;
    end else if (accept) begin
      start_pending <= done;
      found         <= found_new & ~done;
    end
  end

  cnpm_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept & done),
    .push_matched (matched),
    .full         (buf_full),
    .rsp          (rsp)
  );

endmodule
